### rtl/dmwbc_pkg.sv
package dmwbc_pkg;

   localparam int CACHE_WORDS_DEF     = 8192;
   localparam int MAX_LINES_DEF       = 8192;
   localparam int MAX_BLOCK_WORDS_DEF = 64;
   localparam int ADDR_BITS_DEF       = 18;

   localparam int DATA_W  = 32;
   localparam int CFG_W   = 4;
   localparam int COUNT_W = 32;
   localparam int DIRTY_W = 14;

   localparam logic [0:0] CSR_OFFSET_BITS = 1'b0;
   localparam logic [0:0] CSR_INDEX_BITS  = 1'b1;

   localparam logic CMD_READ  = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [CFG_W-1:0] OFFSET_RESET = 4'd5;
   localparam logic [CFG_W-1:0] INDEX_RESET  = 4'd10;

endpackage

### rtl/dmwbc_front.sv
module dmwbc_front import dmwbc_pkg::*; #(
   parameter int CACHE_WORDS     = CACHE_WORDS_DEF,
   parameter int MAX_LINES       = MAX_LINES_DEF,
   parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
   parameter int ADDR_BITS       = ADDR_BITS_DEF,
   parameter int QW              = 1 + ADDR_BITS + DATA_W + 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_cmd,
   input  logic [17:0]      req_addr,
   input  logic [31:0]      req_write_word,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [0:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data,
   output logic             q_valid,
   input  logic             q_take,
   output logic [QW-1:0]    q_item
);

   localparam int QD = 2;

   logic [CFG_W-1:0] offset_ff, offset_in, index_ff, index_in;
   logic [3:0]       geo_o, geo_i;
   logic [QW-1:0]    q_ff [QD];
   logic [QW-1:0]    q_in [QD];
   logic [1:0]       cnt_ff, cnt_in;
   logic             push_ok;
   logic [ADDR_BITS-1:0] a_ext;

   assign csr_ready = 1'b1;
   assign req_full  = (cnt_ff == 2'(QD));
   assign push_ok   = req_push && !req_full;
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_item    = q_ff[0];

   always_comb begin
      logic [3:0] o, i;
      o = offset_ff;
      i = index_ff;
      if (o < 4'd2) o = 4'd2;
      if (o > 4'd8) o = 4'd8;
      for (int s = 0; s < 7; s++) begin
         if (o > 4'd2 && (1 << (o - 4'd2)) > MAX_BLOCK_WORDS) o = o - 4'd1;
      end
      if (i > 4'd13) i = 4'd13;
      for (int s = 0; s < 14; s++) begin
         if (i > 4'd0 && ((1 << i) > MAX_LINES ||
                          (1 << (5'(i) + 5'(o) - 5'd2)) > CACHE_WORDS))
            i = i - 4'd1;
      end
      geo_o = o;
      geo_i = i;
   end

   always_comb begin
      offset_in = offset_ff;
      index_in  = index_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_OFFSET_BITS: offset_in = csr_data;
            CSR_INDEX_BITS:  index_in  = csr_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      a_ext = '0;
      for (int b = 0; b < ADDR_BITS && b < 18; b++) a_ext[b] = req_addr[b];
   end

   always_comb begin
      logic [1:0] c;
      for (int e = 0; e < QD; e++) q_in[e] = q_ff[e];
      c = cnt_ff;
      if (q_take && q_valid) begin
         q_in[0] = q_ff[1];
         c = c - 2'd1;
      end
      if (push_ok) begin
         q_in[c[0]] = {req_cmd, a_ext, req_write_word, geo_o, geo_i};
         c = c + 2'd1;
      end
      cnt_in = c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= OFFSET_RESET;
         index_ff  <= INDEX_RESET;
         cnt_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         index_ff  <= index_in;
         cnt_ff    <= cnt_in;
      end
      for (int e = 0; e < QD; e++) q_ff[e] <= q_in[e];
   end

endmodule

### rtl/dmwbc_back.sv
module dmwbc_back import dmwbc_pkg::*; #(
   parameter int CACHE_WORDS     = CACHE_WORDS_DEF,
   parameter int MAX_LINES       = MAX_LINES_DEF,
   parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
   parameter int ADDR_BITS       = ADDR_BITS_DEF,
   parameter int QW              = 1 + ADDR_BITS + DATA_W + 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   output logic              q_take,
   input  logic [QW-1:0]     q_item,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic              rsp_hit,
   output logic              rsp_wrote_back,
   output logic [31:0]       rsp_read_word,
   output logic [31:0]       rsp_hit_count,
   output logic [31:0]       rsp_miss_count,
   output logic [13:0]       rsp_dirty_lines,
   output logic              clearing
);

   localparam int SW = ADDR_BITS - 2;
   localparam int SD = 1 << SW;
   localparam int LW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
   localparam int CW = $clog2(CACHE_WORDS);
   localparam int TW = ADDR_BITS;
   localparam int BW = 7;

   typedef enum logic [8:0] {
      ST_CLEAR = 9'b000000001,
      ST_IDLE  = 9'b000000010,
      ST_LOOK  = 9'b000000100,
      ST_WBRD  = 9'b000001000,
      ST_WB    = 9'b000010000,
      ST_FILL  = 9'b000100000,
      ST_FILLW = 9'b001000000,
      ST_ACC   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   logic [DATA_W-1:0] store_mem [SD];
   logic [DATA_W-1:0] data_mem [CACHE_WORDS];
   logic [TW-1:0]     tag_mem [MAX_LINES];
   logic              valid_mem [MAX_LINES];
   logic              dirty_mem [MAX_LINES];

   logic [SW-1:0] clr_ff, clr_in;
   logic          cmd_ff;
   logic [ADDR_BITS-1:0] addr_ff;
   logic [DATA_W-1:0]    wdata_ff;
   logic [3:0]    o_ff, i_ff;
   logic [LW-1:0] idx_ff;
   logic [CW-1:0] base_ff, word_ff;
   logic [TW-1:0] tag_rd_ff;
   logic          valid_rd_ff, dirty_rd_ff, dirty_now_ff;
   logic          hit_ff, wb_ff;
   logic [BW-1:0] k_ff, k_in;
   logic [BW-1:0] bw_ff;
   logic [DATA_W-1:0] drd_ff, srd_ff;
   logic [SW-1:0] vword_ff, nword_ff;
   logic [31:0]   hits_ff, miss_ff;
   logic [13:0]   dirty_cnt_ff;
   logic          out_hit_ff, out_wb_ff;
   logic [31:0]   out_word_ff, out_hits_ff, out_miss_ff;
   logic [13:0]   out_dirty_ff;
   logic          out_full_ff;
   logic          look_hit;

   logic          q_cmd;
   logic [ADDR_BITS-1:0] q_addr;
   logic [DATA_W-1:0]    q_wdata;
   logic [3:0]    q_o, q_i;
   logic [ADDR_BITS-1:0] q_idx_full;

   assign {q_cmd, q_addr, q_wdata, q_o, q_i} = q_item;
   assign q_idx_full = (q_addr >> q_o) & ((ADDR_BITS'(1) << q_i) - ADDR_BITS'(1));
   assign clearing = (state_ff == ST_CLEAR);
   assign q_take   = (state_ff == ST_IDLE) && q_valid;

   assign rsp_empty       = !out_full_ff;
   assign rsp_hit         = out_hit_ff;
   assign rsp_wrote_back  = out_wb_ff;
   assign rsp_read_word   = out_word_ff;
   assign rsp_hit_count   = out_hits_ff;
   assign rsp_miss_count  = out_miss_ff;
   assign rsp_dirty_lines = out_dirty_ff;

   logic [ADDR_BITS-1:0] word_mask;
   logic [ADDR_BITS-1:0] idx_full, tag_full;
   always_comb begin
      idx_full = (addr_ff >> o_ff) & ((ADDR_BITS'(1) << i_ff) - ADDR_BITS'(1));
      tag_full = addr_ff >> (o_ff + i_ff);
      word_mask = (ADDR_BITS'(1) << (o_ff - 4'd2)) - ADDR_BITS'(1);
   end

   assign look_hit = valid_rd_ff && (tag_rd_ff == tag_full);

   logic [CW-1:0] k_addr;
   assign k_addr = base_ff + CW'(k_ff);

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      k_in     = k_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == SW'(SD - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: if (q_valid) state_in = ST_LOOK;
         ST_LOOK: begin
            k_in = '0;
            if (look_hit)
               state_in = ST_ACC;
            else if (valid_rd_ff && dirty_rd_ff)
               state_in = ST_WBRD;
            else
               state_in = ST_FILL;
         end
         ST_WBRD: state_in = ST_WB;
         ST_WB: begin
            k_in = k_ff + 1'b1;
            state_in = ST_WBRD;
            if (k_ff + 1'b1 == bw_ff) begin
               k_in = '0;
               state_in = ST_FILL;
            end
         end
         ST_FILL: state_in = ST_FILLW;
         ST_FILLW: begin
            k_in = k_ff + 1'b1;
            state_in = ST_FILL;
            if (k_ff + 1'b1 == bw_ff) state_in = ST_ACC;
         end
         ST_ACC: state_in = ST_OUT;
         ST_OUT: if (!out_full_ff || rsp_pop) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         hits_ff      <= '0;
         miss_ff      <= '0;
         dirty_cnt_ff <= '0;
         out_full_ff  <= 1'b0;
         k_ff         <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         k_ff     <= k_in;
         if (state_ff == ST_OUT && (!out_full_ff || rsp_pop)) out_full_ff <= 1'b1;
         else if (out_full_ff && rsp_pop) out_full_ff <= 1'b0;
         unique case (state_ff)
            ST_LOOK: begin
               if (look_hit) begin
                  if (hits_ff != '1) hits_ff <= hits_ff + 1'b1;
               end else begin
                  if (miss_ff != '1) miss_ff <= miss_ff + 1'b1;
                  if (dirty_rd_ff && dirty_cnt_ff != '0)
                     dirty_cnt_ff <= dirty_cnt_ff - 1'b1;
               end
            end
            ST_ACC: begin
               if (cmd_ff == CMD_WRITE && !dirty_now_ff)
                  dirty_cnt_ff <= dirty_cnt_ff + 1'b1;
            end
            default: ;
         endcase
      end
   end

   // line lookup: tag, valid and dirty read at take time, ready in ST_LOOK
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE) begin
         tag_rd_ff   <= tag_mem[q_idx_full[LW-1:0]];
         valid_rd_ff <= valid_mem[q_idx_full[LW-1:0]];
         dirty_rd_ff <= dirty_mem[q_idx_full[LW-1:0]];
      end
      if (state_ff == ST_CLEAR) begin
         valid_mem[LW'(clr_ff)] <= 1'b0;
         dirty_mem[LW'(clr_ff)] <= 1'b0;
      end else if (state_ff == ST_LOOK && !look_hit) begin
         valid_mem[idx_full[LW-1:0]] <= 1'b1;
         dirty_mem[idx_full[LW-1:0]] <= 1'b0;
         tag_mem[idx_full[LW-1:0]]   <= tag_full;
      end else if (state_ff == ST_ACC && cmd_ff == CMD_WRITE) begin
         dirty_mem[idx_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && q_valid) begin
         cmd_ff   <= q_cmd;
         addr_ff  <= q_addr;
         wdata_ff <= q_wdata;
         o_ff     <= q_o;
         i_ff     <= q_i;
      end
      if (state_ff == ST_LOOK) begin
         idx_ff       <= idx_full[LW-1:0];
         base_ff      <= CW'(idx_full << (o_ff - 4'd2));
         word_ff      <= CW'((addr_ff >> 2) & word_mask);
         bw_ff        <= BW'(1 << (o_ff - 4'd2));
         hit_ff       <= look_hit;
         wb_ff        <= !look_hit && valid_rd_ff && dirty_rd_ff;
         dirty_now_ff <= look_hit && dirty_rd_ff;
         vword_ff     <= SW'(((tag_rd_ff << (o_ff + i_ff)) | (idx_full << o_ff)) >> 2);
         nword_ff     <= SW'((addr_ff >> 2) & ~word_mask);
      end
      if (state_ff == ST_OUT && (!out_full_ff || rsp_pop)) begin
         out_hit_ff   <= hit_ff;
         out_wb_ff    <= wb_ff;
         out_word_ff  <= (cmd_ff == CMD_WRITE) ? wdata_ff : drd_ff;
         out_hits_ff  <= hits_ff;
         out_miss_ff  <= miss_ff;
         out_dirty_ff <= dirty_cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_WBRD || state_ff == ST_ACC)
         drd_ff <= data_mem[state_ff == ST_ACC ? base_ff + word_ff : k_addr];
      if (state_ff == ST_FILLW) data_mem[k_addr] <= srd_ff;
      else if (state_ff == ST_ACC && cmd_ff == CMD_WRITE)
         data_mem[base_ff + word_ff] <= wdata_ff;
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_FILL) srd_ff <= store_mem[nword_ff + SW'(k_ff)];
      if (state_ff == ST_CLEAR) store_mem[clr_ff] <= '0;
      else if (state_ff == ST_WB) store_mem[vword_ff + SW'(k_ff)] <= drd_ff;
   end

endmodule

### rtl/direct_mapped_writeback_cache_top.sv
// flow: a hit passes through lookup, access and output; a miss first writes back the
// old line word by word when it is dirty, then refills the line word by word from the store
// items: the back end handles one item at a time, and two items queue
// in front of it
// reset: synchronous; afterwards a clearing pass over the backing store zeroes it and the
// line valid and dirty marks, during which no item is taken
module direct_mapped_writeback_cache_top import dmwbc_pkg::*; #(
   parameter int CACHE_WORDS     = CACHE_WORDS_DEF,
   parameter int MAX_LINES       = MAX_LINES_DEF,
   parameter int MAX_BLOCK_WORDS = MAX_BLOCK_WORDS_DEF,
   parameter int ADDR_BITS       = ADDR_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_cmd,
   input  logic [17:0] req_addr,
   input  logic [31:0] req_write_word,
   output logic        empty,
   input  logic        pop,
   output logic        rsp_hit,
   output logic        rsp_wrote_back,
   output logic [31:0] rsp_read_word,
   output logic [31:0] rsp_hit_count,
   output logic [31:0] rsp_miss_count,
   output logic [13:0] rsp_dirty_lines,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [3:0]  csr_data
);

   localparam int QW = 1 + ADDR_BITS + DATA_W + 8;

   logic          q_valid, q_take, clearing, front_full;
   logic [QW-1:0] q_item;

   assign full = front_full || clearing;

   dmwbc_front #(
      .CACHE_WORDS(CACHE_WORDS), .MAX_LINES(MAX_LINES),
      .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS), .ADDR_BITS(ADDR_BITS), .QW(QW)
   ) u_front (
      .clock, .reset,
      .req_push(push && !clearing), .req_full(front_full),
      .req_cmd, .req_addr, .req_write_word,
      .csr_valid, .csr_ready, .csr_index, .csr_data,
      .q_valid, .q_take, .q_item
   );

   dmwbc_back #(
      .CACHE_WORDS(CACHE_WORDS), .MAX_LINES(MAX_LINES),
      .MAX_BLOCK_WORDS(MAX_BLOCK_WORDS), .ADDR_BITS(ADDR_BITS), .QW(QW)
   ) u_back (
      .clock, .reset,
      .q_valid, .q_take, .q_item,
      .rsp_empty(empty), .rsp_pop(pop),
      .rsp_hit, .rsp_wrote_back, .rsp_read_word,
      .rsp_hit_count, .rsp_miss_count, .rsp_dirty_lines,
      .clearing
   );

endmodule
